// ===== rtl/core/devu_pkg.sv =====
package devu_pkg;

	localparam int FREQ_W     = 27;
	localparam int CURSOR_W   = 3;
	localparam int NUM_DIGITS = 8;
	localparam int DIG_W      = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
	localparam int STEP_W     = $clog2(10 ** (NUM_DIGITS - 1) + 1);
	localparam int SUM_W      = ((STEP_W > FREQ_W) ? STEP_W : FREQ_W) + 1;

	localparam logic [FREQ_W-1:0] FREQ_LIMIT_RST = FREQ_W'(100000000);
	localparam logic [FREQ_W-1:0] FREQ0_RST      = FREQ_W'(0);
	localparam logic [FREQ_W-1:0] FREQ1_RST      = FREQ_W'(50);
	localparam logic [DIG_W-1:0]  DIG_RST        = DIG_W'(1);

	// decoded step, two's complement
	localparam logic [1:0] DIR_NONE = 2'b00;
	localparam logic [1:0] DIR_UP   = 2'b01;
	localparam logic [1:0] DIR_DOWN = 2'b11;

	// encoder line pair {B, A}
	localparam logic [1:0] AB_NONE   = 2'b00;
	localparam logic [1:0] AB_B_ONLY = 2'b10;
	localparam logic [1:0] AB_BOTH   = 2'b11;

	function automatic logic [STEP_W-1:0] pow10(input int unsigned n);
		logic [STEP_W-1:0] p;
		p = STEP_W'(1);
		for (int unsigned i = 0; i < n; i++) begin
			p = STEP_W'(p * STEP_W'(10));
		end
		return p;
	endfunction

endpackage

// ===== rtl/core/encoder_decimal_value_editor_unit.sv =====
// Rotary encoder decimal value editor.
//
// Slave stream: one transfer per sampled tick of the encoder lines, with the
// digit-shift press and the phase-mode flag in s_axis_tdata and the edited
// register index in s_axis_tuser. Master stream: exactly one result per input
// transfer, in order: decoded direction, update strobe, the selected value in
// tenths of a hertz and the cursor digit in m_axis_tdata, register index in
// m_axis_tuser.
// The user must write the ceiling (cfg_wr_en/cfg_wr_data) only while the block is idle; the block does not check.
// An item passes through an input register, the decode and add/clamp logic, then
// the output register. Throughput is one transfer per cycle while the receiver
// does not stall; the stored values and cursor are updated in the same cycle that
// moves an item to the output register, so the next item sees them at once.
// When the receiver stalls, the output register holds and the input register
// fills; s_axis_tready then drops until the output is taken.
// Reset (arst_n low) empties both registers, sets the cursor to digit 1, the
// stored values to 0 and 50, and the ceiling to 100000000.
module encoder_decimal_value_editor_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_wr_en,
	input  logic [devu_pkg::FREQ_W-1:0]  cfg_wr_data,   // freq_limit
	input  logic                         s_axis_tvalid,
	output logic                         s_axis_tready,
	input  logic [7:0]                   s_axis_tdata,  // line_a, line_b, digit_shift, edit_phase, 0
	input  logic                         s_axis_tuser,  // register_select
	output logic                         m_axis_tvalid,
	input  logic                         m_axis_tready,
	output logic [39:0]                  m_axis_tdata,  // direction[1:0], update, freq_tenths[26:0], cursor_digit[2:0], 0
	output logic                         m_axis_tuser   // register_out
);

	localparam int FW = devu_pkg::FREQ_W;
	localparam int DW = devu_pkg::DIG_W;
	localparam int SW = devu_pkg::SUM_W;
	localparam int PW = devu_pkg::STEP_W;
	localparam int CW = devu_pkg::CURSOR_W;
	localparam int ND = devu_pkg::NUM_DIGITS;

	// input register
	logic             valid_s1;
	logic             line_a_s1;
	logic             line_b_s1;
	logic             shift_s1;
	logic             phase_s1;
	logic             sel_s1;

	// output register
	logic             valid_s2;
	logic [1:0]       dir_s2;
	logic             update_s2;
	logic             sel_s2;
	logic [FW-1:0]    freq_s2;
	logic [CW-1:0]    cursor_s2;

	// editor state
	logic [FW-1:0]    freq_limit_q;
	logic             last_a_q;
	logic [1:0]       last_ab_q;
	logic [DW-1:0]    digit_q;
	logic [FW-1:0]    freq_q [2];

	logic             advance;
	logic             fire;

	logic [PW-1:0]    step_lut [ND];
	logic [DW-1:0]    digit_nxt;
	logic [1:0]       now_ab;
	logic             a_change;
	logic [1:0]       dir;
	logic [1:0]       last_ab_nxt;
	logic [FW-1:0]    v_cur;
	logic [PW-1:0]    step;
	logic [SW-1:0]    v_ext;
	logic [SW-1:0]    p_ext;
	logic [SW-1:0]    v_new;
	logic [FW-1:0]    v_clamp;
	logic             write_en;
	logic [FW-1:0]    freq_res;
	logic [DW+CW-1:0] digit_ext;

	genvar gi;
	generate
		for (gi = 0; gi < ND; gi++) begin : g_lut
			assign step_lut[gi] = devu_pkg::pow10(gi);
		end
	endgenerate

	assign advance       = !valid_s2 || m_axis_tready;
	assign fire          = valid_s1 && advance;
	assign s_axis_tready = !valid_s1 || advance;

	always_comb begin
		// cursor shift comes before this tick's step
		digit_nxt = digit_q;
		if (shift_s1) begin
			if (digit_q == '0 || {1'b0, digit_q} >= (DW+1)'(ND)) begin
				digit_nxt = DW'(ND - 1);
			end else begin
				digit_nxt = digit_q - DW'(1);
			end
		end

		now_ab      = {line_b_s1, line_a_s1};
		a_change    = line_a_s1 != last_a_q;
		dir         = devu_pkg::DIR_NONE;
		last_ab_nxt = last_ab_q;
		if (a_change) begin
			if (now_ab == devu_pkg::AB_BOTH) begin
				if (last_ab_q == devu_pkg::AB_B_ONLY) begin
					dir = devu_pkg::DIR_DOWN;
				end else if (last_ab_q == devu_pkg::AB_NONE) begin
					dir = devu_pkg::DIR_UP;
				end
			end
			last_ab_nxt = now_ab;
		end

		v_cur = freq_q[sel_s1];
		step  = ({1'b0, digit_nxt} < (DW+1)'(ND)) ? step_lut[digit_nxt] : '0;
		v_ext = SW'(v_cur);
		p_ext = SW'(step);

		case (dir)
			devu_pkg::DIR_DOWN: v_new = (p_ext > v_ext) ? '0 : v_ext - p_ext;
			devu_pkg::DIR_UP:   v_new = v_ext + p_ext;
			default:            v_new = v_ext;
		endcase

		v_clamp  = (v_new >= SW'(freq_limit_q)) ? freq_limit_q : v_new[FW-1:0];
		write_en = !phase_s1 && !(dir == devu_pkg::DIR_DOWN && v_cur == '0);
		freq_res = write_en ? v_clamp : v_cur;

		digit_ext = {{CW{1'b0}}, digit_nxt};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			line_a_s1 <= s_axis_tdata[0];
			line_b_s1 <= s_axis_tdata[1];
			shift_s1  <= s_axis_tdata[2];
			phase_s1  <= s_axis_tdata[3];
			sel_s1    <= s_axis_tuser;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			dir_s2    <= dir;
			update_s2 <= dir != devu_pkg::DIR_NONE && !phase_s1;
			sel_s2    <= sel_s1;
			freq_s2   <= freq_res;
			cursor_s2 <= digit_ext[CW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			freq_limit_q <= devu_pkg::FREQ_LIMIT_RST;
			last_a_q     <= 1'b0;
			last_ab_q    <= devu_pkg::AB_NONE;
			digit_q      <= devu_pkg::DIG_RST;
			freq_q[0]    <= devu_pkg::FREQ0_RST;
			freq_q[1]    <= devu_pkg::FREQ1_RST;
		end else begin
			if (cfg_wr_en) begin
				freq_limit_q <= cfg_wr_data;
			end
			if (fire) begin
				last_a_q        <= line_a_s1;
				last_ab_q       <= last_ab_nxt;
				digit_q         <= digit_nxt;
				freq_q[sel_s1]  <= freq_res;
			end
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {7'b0, cursor_s2, freq_s2, update_s2, dir_s2};
	assign m_axis_tuser  = sel_s2;

	// update is only ever raised with a real step
	a_update_has_step: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && update_s2) |-> (dir_s2 != devu_pkg::DIR_NONE))
		else $error("update without a decoded step");

	// cursor never leaves the digit range
	a_cursor_range: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, digit_q} < (DW+1)'(ND))
		else $error("cursor digit out of range");

	// an empty output register never blocks the input side
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s2 |-> s_axis_tready)
		else $error("input stalled with empty output register");

	// editor state other than the ceiling moves only when an item is retired into the output register
	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!fire |=> ($stable(digit_q) && $stable(last_a_q) && $stable(last_ab_q)))
		else $error("editor state changed without a transfer");

endmodule
